[rtl/reprojection_error_accumulator_core_assert.svh]
// Assertion macros for the reprojection error accumulator checker
`ifndef REPROJECTION_ERROR_ACCUMULATOR_CORE_ASSERT_SVH
`define REPROJECTION_ERROR_ACCUMULATOR_CORE_ASSERT_SVH

// same-cycle implication
`define REA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define REA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rea_pkg.sv]
// Shared types and constants for the reprojection error accumulator
`timescale 1ns / 1ps
package rea_pkg;
  localparam int FRAC_BITS      = 16;
  localparam int CAM_WORDS      = 21;
  localparam int T_BASE         = 9;
  localparam int K_BASE         = 12;
  localparam int ZERO_DEPTH_DEN = 100000;
  localparam int ZERO_DEPTH_LIM = ((1 << FRAC_BITS) - 1) / ZERO_DEPTH_DEN + 1;
  localparam int NUM_W          = 33 + FRAC_BITS;
  localparam int DCNT_W         = $clog2(NUM_W);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_OBS  = 1'b1;

  typedef struct packed {
    logic               op;
    logic [4:0]         word_index;
    logic signed [31:0] word_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] corner_u;
    logic signed [31:0] corner_v;
    logic               last_obs;
  } req_t;

  typedef struct packed {
    logic [63:0] error_sum;
    logic        zero_depth_seen;
    logic        saturated;
  } res_t;

  typedef struct packed {
    logic               kind;
    logic [4:0]         addr;
    logic signed [31:0] value;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] cu;
    logic signed [31:0] cv;
    logic               last;
  } qent_t;
endpackage

[rtl/rea_front.sv]
// Front stage: accepts beats, drops out-of-range loads, registers entries
`timescale 1ns / 1ps
module rea_front import rea_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  input  req_t  req,
  output logic  req_stall,
  output logic  ent_valid,
  output qent_t ent,
  input  logic  ent_stall
);
  logic  hold_valid;
  qent_t hold;
  logic  keep;

  assign req_stall = hold_valid && ent_stall;
  assign keep      = (req.op == OP_OBS) || (req.word_index < 5'(CAM_WORDS));
  assign ent_valid = hold_valid;
  assign ent       = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!req_stall) begin
      hold_valid <= req_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      hold.kind  <= req.op;
      hold.addr  <= req.word_index;
      hold.value <= req.word_value;
      hold.px    <= req.point_x;
      hold.py    <= req.point_y;
      hold.pz    <= req.point_z;
      hold.cu    <= req.corner_u;
      hold.cv    <= req.corner_v;
      hold.last  <= req.last_obs;
    end
  end
endmodule

[rtl/rea_queue.sv]
// Two-entry queue between front and back
`timescale 1ns / 1ps
module rea_queue import rea_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  input  qent_t push_data,
  output logic  push_stall,
  output logic  pop_valid,
  output qent_t pop_data,
  input  logic  pop
);
  qent_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;

  assign push_stall = (count == 2'd2);
  assign do_push    = push_valid && !push_stall;
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(do_push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end
endmodule

[rtl/rea_back.sv]
// Back end: camera store, shared multiplier, bit-serial divider, sum
`timescale 1ns / 1ps
module rea_back import rea_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  ent_valid,
  input  qent_t ent,
  output logic  ent_pop,
  output logic  res_valid,
  output res_t  res,
  input  logic  res_stall
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_BRD  = 4'd1;
  localparam logic [3:0] S_BIAS = 4'd2;
  localparam logic [3:0] S_RD   = 4'd3;
  localparam logic [3:0] S_MUL  = 4'd4;
  localparam logic [3:0] S_ACC  = 4'd5;
  localparam logic [3:0] S_DCHK = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_DFIN = 4'd8;
  localparam logic [3:0] S_SQ0  = 4'd9;
  localparam logic [3:0] S_SQ1  = 4'd10;
  localparam logic [3:0] S_SUM1 = 4'd11;
  localparam logic [3:0] S_SUM2 = 4'd12;
  localparam logic [3:0] S_EMIT = 4'd13;

  localparam logic signed [51:0] SAT_HI = 52'sd2147483647;
  localparam logic signed [51:0] SAT_LO = -52'sd2147483648;
  localparam logic [NUM_W-1:0]   Q_NEG_LIM = NUM_W'(64'h80000000);
  localparam logic [NUM_W-1:0]   Q_POS_LIM = NUM_W'(64'h7FFFFFFF);

  logic [3:0]         st;
  qent_t              cur;
  logic               phase;
  logic [1:0]         row;
  logic [1:0]         col;
  logic signed [51:0] acc;
  logic signed [31:0] cvec [3];
  logic signed [31:0] pvec [3];
  logic [31:0]        mem [CAM_WORDS];
  logic [31:0]        rd_data;
  logic [4:0]         rd_addr;
  logic signed [63:0] prod;
  logic [NUM_W-1:0]   dq;
  logic [32:0]        drem;
  logic [32:0]        dden;
  logic [DCNT_W-1:0]  dcnt;
  logic               dsel;
  logic [31:0]        mdx;
  logic [31:0]        mdy;
  logic [63:0]        sqa;
  logic [63:0]        sq;
  logic               clamp_r;
  logic [63:0]        running;
  logic               depth_flag;
  logic               ovf_flag;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_p;
  logic signed [31:0] opnd;
  logic signed [51:0] acc_n;
  logic signed [31:0] acc_sat;
  logic [32:0]        m2;
  logic [33:0]        rem_sh;
  logic               qbit;
  logic               qneg;
  logic [31:0]        qres;
  logic signed [32:0] diff;
  logic [32:0]        dmag;
  logic [64:0]        s1;
  logic [64:0]        s2;
  logic [63:0]        new_sum;
  logic               out_free;

  function automatic logic [32:0] mag33(input logic signed [31:0] a);
    logic [32:0] e;
    e = {a[31], a};
    return a[31] ? 33'(~e + 33'd1) : e;
  endfunction

  assign ent_pop  = (st == S_IDLE) && ent_valid;
  assign out_free = !res_valid || !res_stall;

  always_comb begin
    if (st == S_BRD) rd_addr = 5'(T_BASE) + 5'(row);
    else rd_addr = (phase ? 5'(K_BASE) : 5'd0) + 5'(row) * 5'd3 + 5'(col);
  end

  always_comb begin
    if (phase) opnd = cvec[col];
    else begin
      case (col)
        2'd0:    opnd = cur.px;
        2'd1:    opnd = cur.py;
        default: opnd = cur.pz;
      endcase
    end
  end

  always_comb begin
    mul_a = 33'sd0;
    mul_b = 33'sd0;
    unique case (st)
      S_MUL: begin
        mul_a = {rd_data[31], rd_data};
        mul_b = {opnd[31], opnd};
      end
      S_SQ0: begin
        mul_a = {1'b0, mdx};
        mul_b = {1'b0, mdx};
      end
      S_SQ1: begin
        mul_a = {1'b0, mdy};
        mul_b = {1'b0, mdy};
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign acc_n = acc + 52'(prod >>> FRAC_BITS);
  always_comb begin
    if (acc_n > SAT_HI) acc_sat = 32'sh7FFFFFFF;
    else if (acc_n < SAT_LO) acc_sat = 32'sh80000000;
    else acc_sat = acc_n[31:0];
  end

  assign m2     = mag33(pvec[2]);
  assign rem_sh = {drem, dq[NUM_W-1]};
  assign qbit   = (rem_sh >= {1'b0, dden});
  assign qneg   = (dsel ? pvec[1][31] : pvec[0][31]) != pvec[2][31];

  always_comb begin
    if (qneg) qres = (dq > Q_NEG_LIM) ? 32'h80000000 : (~dq[31:0] + 32'd1);
    else qres = (dq > Q_POS_LIM) ? 32'h7FFFFFFF : dq[31:0];
  end
  assign diff = {qres[31], qres} - (dsel ? {cur.cv[31], cur.cv} : {cur.cu[31], cur.cu});
  assign dmag = diff[32] ? 33'(~diff + 33'sd1) : diff;

  assign s1      = {1'b0, sqa} + {1'b0, prod};
  assign s2      = {1'b0, running} + {1'b0, sq};
  assign new_sum = s2[64] ? {64{1'b1}} : s2[63:0];

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (ent_pop && ent.kind == OP_LOAD) mem[ent.addr] <= ent.value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= S_IDLE;
      res_valid  <= 1'b0;
      running    <= 64'd0;
      depth_flag <= 1'b0;
      ovf_flag   <= 1'b0;
    end else begin
      if (st == S_EMIT && out_free) res_valid <= 1'b1;
      else if (!res_stall) res_valid <= 1'b0;
      unique case (st)
        S_IDLE: begin
          if (ent_valid && ent.kind == OP_OBS) begin
            cur   <= ent;
            phase <= 1'b0;
            row   <= 2'd0;
            col   <= 2'd0;
            st    <= S_BRD;
          end
        end
        S_BRD:  st <= S_BIAS;
        S_BIAS: begin
          acc <= 52'(signed'(rd_data));
          st  <= S_RD;
        end
        S_RD: st <= S_MUL;
        S_MUL: begin
          prod <= mul_p[63:0];
          st   <= S_ACC;
        end
        S_ACC: begin
          if (col == 2'd2) begin
            if (phase) pvec[row] <= acc_sat;
            else cvec[row] <= acc_sat;
            col <= 2'd0;
            acc <= 52'sd0;
            if (row == 2'd2) begin
              row <= 2'd0;
              if (phase) st <= S_DCHK;
              else begin
                phase <= 1'b1;
                st    <= S_RD;
              end
            end else begin
              row <= row + 2'd1;
              st  <= phase ? S_RD : S_BRD;
            end
          end else begin
            col <= col + 2'd1;
            acc <= acc_n;
            st  <= S_RD;
          end
        end
        S_DCHK: begin
          if (m2 < 33'(ZERO_DEPTH_LIM)) begin
            depth_flag <= 1'b1;
            st         <= cur.last ? S_EMIT : S_IDLE;
          end else begin
            dsel <= 1'b0;
            dden <= m2;
            dq   <= NUM_W'(mag33(pvec[0])) << FRAC_BITS;
            drem <= 33'd0;
            dcnt <= '0;
            st   <= S_DIV;
          end
        end
        S_DIV: begin
          drem <= qbit ? 33'(rem_sh - {1'b0, dden}) : rem_sh[32:0];
          dq   <= {dq[NUM_W-2:0], qbit};
          dcnt <= dcnt + 1'b1;
          if (dcnt == DCNT_W'(NUM_W - 1)) st <= S_DFIN;
        end
        S_DFIN: begin
          if (!dsel) begin
            mdx  <= dmag[31:0];
            dsel <= 1'b1;
            dq   <= NUM_W'(mag33(pvec[1])) << FRAC_BITS;
            drem <= 33'd0;
            dcnt <= '0;
            st   <= S_DIV;
          end else begin
            mdy <= dmag[31:0];
            st  <= S_SQ0;
          end
        end
        S_SQ0: begin
          prod <= mul_p[63:0];
          st   <= S_SQ1;
        end
        S_SQ1: begin
          sqa  <= prod;
          prod <= mul_p[63:0];
          st   <= S_SUM1;
        end
        S_SUM1: begin
          sq      <= s1[64] ? {64{1'b1}} : s1[63:0];
          clamp_r <= s1[64];
          st      <= S_SUM2;
        end
        S_SUM2: begin
          running <= new_sum;
          if (clamp_r || s2[64] || new_sum == {64{1'b1}}) ovf_flag <= 1'b1;
          st <= cur.last ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (out_free) begin
            res.error_sum       <= running;
            res.zero_depth_seen <= depth_flag;
            res.saturated       <= ovf_flag;
            running             <= 64'd0;
            depth_flag          <= 1'b0;
            ovf_flag            <= 1'b0;
            st                  <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule

[rtl/reprojection_error_accumulator_core.sv]
// Top level of the reprojection error accumulator
// A load beat passes the front register and the queue and is written to
// the camera store when the idle back end pops it. An observation's sum
// is updated when its processing ends; a last observation's result beat
// follows once the output is free. The back end pops only when idle, so
// the shared multiplier's read-multiply-accumulate loop and two 49-step
// dividers pace observations. Reset clears the sum, the flags and all
// handshake state; camera words keep no reset value and must be loaded before use.
`timescale 1ns / 1ps
module reprojection_error_accumulator_core import rea_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  req_t req,
  output logic req_stall,
  output logic res_valid,
  output res_t res,
  input  logic res_stall
);
  logic  f_valid;
  qent_t f_ent;
  logic  f_stall;
  logic  q_valid;
  qent_t q_ent;
  logic  q_pop;

  rea_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .req_stall (req_stall),
    .ent_valid (f_valid),
    .ent       (f_ent),
    .ent_stall (f_stall)
  );

  rea_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_data  (f_ent),
    .push_stall (f_stall),
    .pop_valid  (q_valid),
    .pop_data   (q_ent),
    .pop        (q_pop)
  );

  rea_back u_back (
    .clk       (clk),
    .rst       (rst),
    .ent_valid (q_valid),
    .ent       (q_ent),
    .ent_pop   (q_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_stall (res_stall)
  );
endmodule

[rtl/rea_checker.sv]
// Port-level checks on the result channel, bound to the top level
`timescale 1ns / 1ps
`include "reprojection_error_accumulator_core_assert.svh"
module rea_checker import rea_pkg::*; (
  input logic clk,
  input logic rst,
  input logic res_valid,
  input res_t res,
  input logic res_stall
);
  `REA_ASSERT_NEXT(a_hold_valid, res_valid && res_stall, res_valid, "result beat dropped")
  `REA_ASSERT_NEXT(a_hold_data, res_valid && res_stall, $stable(res), "stalled result changed")
  `REA_ASSERT_SAME(a_sat_max, res_valid, res.saturated == (&res.error_sum), "sat flag mismatch")
endmodule

bind reprojection_error_accumulator_core rea_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res       (res),
  .res_stall (res_stall)
);

[tb/sv/tb_reprojection_error_accumulator_core.sv]
// Testbench for the reprojection error accumulator: random beats checked against a predictor
`timescale 1ns / 1ps
module tb_reprojection_error_accumulator_core;
  import rea_pkg::*;

  localparam int  N_RANDOM = 1620;
  localparam int  TAIL     = 150;
  localparam longint LIMIT = 3000000;
  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  req_t req = '0;
  logic req_stall;
  logic res_valid;
  res_t res;
  logic res_stall = 1'b0;

  reprojection_error_accumulator_core dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req(req), .req_stall(req_stall),
    .res_valid(res_valid), .res(res), .res_stall(res_stall)
  );

  req_t pending[$];
  res_t sums_due[$];
  logic [31:0] cam[CAM_WORDS];
  logic [63:0] acc_sum;
  logic depth_seen, clamp_seen;
  int fails = 0;
  int results_seen = 0;
  longint cycles = 0;
  int send_gap = 0, recv_gap = 0, hold_left = 0;
  bit hold_done = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic longint clamp32(longint v);
    if (v > I32_MAX) return I32_MAX;
    if (v < I32_MIN) return I32_MIN;
    return v;
  endfunction

  function automatic longint camw(int i);
    return longint'($signed(cam[i]));
  endfunction

  function automatic longint row_mac(int base, longint a, longint b, longint c, longint bias);
    longint acc;
    acc = bias;
    acc += (camw(base) * a) >>> FRAC_BITS;
    acc += (camw(base + 1) * b) >>> FRAC_BITS;
    acc += (camw(base + 2) * c) >>> FRAC_BITS;
    return clamp32(acc);
  endfunction

  function automatic logic [63:0] absval(longint a);
    return a < 0 ? 64'(-a) : 64'(a);
  endfunction

  function automatic longint pix_div(longint num, longint den);
    logic [63:0] q;
    q = (absval(num) << FRAC_BITS) / absval(den);
    if ((num < 0) != (den < 0)) return q > 64'h8000_0000 ? I32_MIN : -longint'(q);
    return q > 64'h7FFF_FFFF ? I32_MAX : longint'(q);
  endfunction

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b, ref logic clamped);
    logic [63:0] s;
    s = a + b;
    if (s < a) begin
      clamped = 1'b1;
      return '1;
    end
    return s;
  endfunction

  task automatic predict_beat(req_t b);
    longint c0, c1, c2, p0, p1, p2, dx, dy;
    logic [63:0] sq;
    logic clamped;
    res_t r;
    clamped = 1'b0;
    if (b.op == OP_LOAD) begin
      if (b.word_index < CAM_WORDS) cam[b.word_index] = b.word_value;
      return;
    end
    c0 = row_mac(0, $signed(b.point_x), $signed(b.point_y), $signed(b.point_z), camw(T_BASE));
    c1 = row_mac(3, $signed(b.point_x), $signed(b.point_y), $signed(b.point_z),
                 camw(T_BASE + 1));
    c2 = row_mac(6, $signed(b.point_x), $signed(b.point_y), $signed(b.point_z),
                 camw(T_BASE + 2));
    p0 = row_mac(K_BASE, c0, c1, c2, 0);
    p1 = row_mac(K_BASE + 3, c0, c1, c2, 0);
    p2 = row_mac(K_BASE + 6, c0, c1, c2, 0);
    if (absval(p2) * ZERO_DEPTH_DEN < (64'd1 << FRAC_BITS)) begin
      depth_seen = 1'b1;
    end else begin
      dx = pix_div(p0, p2) - longint'($signed(b.corner_u));
      dy = pix_div(p1, p2) - longint'($signed(b.corner_v));
      sq = sat_sum(absval(dx) * absval(dx), absval(dy) * absval(dy), clamped);
      acc_sum = sat_sum(acc_sum, sq, clamped);
      if (clamped || acc_sum == '1) clamp_seen = 1'b1;
    end
    if (!b.last_obs) return;
    r.error_sum = acc_sum;
    r.zero_depth_seen = depth_seen;
    r.saturated = clamp_seen;
    sums_due.push_back(r);
    acc_sum = '0;
    depth_seen = 1'b0;
    clamp_seen = 1'b0;
  endtask

  function automatic req_t noise_beat();
    req_t b;
    b.op = 1'($urandom);
    b.word_index = 5'($urandom);
    b.word_value = $urandom;
    b.point_x = $urandom;
    b.point_y = $urandom;
    b.point_z = $urandom;
    b.corner_u = $urandom;
    b.corner_v = $urandom;
    b.last_obs = 1'($urandom);
    return b;
  endfunction

  function automatic req_t load_beat(int idx, logic [31:0] val, logic last);
    req_t b;
    b = noise_beat();
    b.op = OP_LOAD;
    b.word_index = idx[4:0];
    b.word_value = val;
    b.last_obs = last;
    return b;
  endfunction

  function automatic req_t obs_beat(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                    logic [31:0] u, logic [31:0] v, logic last);
    req_t b;
    b = noise_beat();
    b.op = OP_OBS;
    b.point_x = x;
    b.point_y = y;
    b.point_z = z;
    b.corner_u = u;
    b.corner_v = v;
    b.last_obs = last;
    return b;
  endfunction

  // nominal camera: identity rotation, depth offset 10, focal 400, centre (320,240)
  function automatic logic [31:0] nominal_word(int i);
    case (i)
      0, 4, 8: return 32'sd1 << FRAC_BITS;
      T_BASE + 2: return 32'sd10 << FRAC_BITS;
      K_BASE, K_BASE + 4: return 32'sd400 << FRAC_BITS;
      K_BASE + 2: return 32'sd320 << FRAC_BITS;
      K_BASE + 5: return 32'sd240 << FRAC_BITS;
      K_BASE + 8: return 32'sd1 << FRAC_BITS;
      default: return 32'd0;
    endcase
  endfunction

  task automatic load_nominal(bit jitter);
    logic [31:0] w;
    for (int i = 0; i < CAM_WORDS; i++) begin
      w = nominal_word(i);
      if (jitter) w = w + $urandom_range(0, 4095) - 2048;
      pending.push_back(load_beat(i, w, 1'($urandom_range(0, 1))));
    end
  endtask

  function automatic req_t plausible_obs(logic last);
    return obs_beat($urandom_range(0, 8 << FRAC_BITS) - (4 << FRAC_BITS),
                    $urandom_range(0, 8 << FRAC_BITS) - (4 << FRAC_BITS),
                    $urandom_range(0, 30 << FRAC_BITS) - (9 << FRAC_BITS),
                    $urandom_range(0, 640 << FRAC_BITS),
                    $urandom_range(0, 480 << FRAC_BITS), last);
  endfunction

  initial begin
    int pick;
    load_nominal(0);
    pending.push_back(obs_beat(0, 0, 0, 32'sd320 << FRAC_BITS, 32'sd240 << FRAC_BITS, 1'b1));
    pending.push_back(obs_beat(32'sd1 << FRAC_BITS, 0, 0, 0, 0, 1'b0));
    // point on the camera plane: depth exactly zero
    pending.push_back(obs_beat(0, 0, -(32'sd10 << FRAC_BITS), 0, 0, 1'b1));
    pending.push_back(load_beat(31, 32'hFFFF_FFFF, 1'b1));
    pending.push_back(load_beat(21, 32'h8000_0000, 1'b0));
    // extreme coordinates drive the sum into saturation
    pending.push_back(obs_beat(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                               32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
    pending.push_back(obs_beat(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                               32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
    pending.push_back(obs_beat(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                               32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1));
    for (int i = 0; i < N_RANDOM; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        pending.push_back(load_beat($urandom_range(0, 31),
            $urandom_range(0, 1) ? nominal_word($urandom_range(0, 20)) + $urandom_range(0, 8191)
                                   - 4096 : $urandom, 1'($urandom_range(0, 1))));
      end else if (pick < 6) begin
        load_nominal($urandom_range(0, 1));
        i += CAM_WORDS - 1;
      end else if (pick < 14) begin
        pending.push_back(obs_beat($urandom, $urandom, $urandom, $urandom, $urandom,
                                   $urandom_range(0, 7) == 0));
      end else begin
        pending.push_back(plausible_obs($urandom_range(0, 7) == 0));
      end
    end
    pending.push_back(plausible_obs(1'b1));
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    wait (pending.size() == 0 && !req_valid);
    wait (sums_due.size() == 0);
    repeat (400) @(posedge clk);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // sender
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      acc_sum = '0;
      depth_seen = 1'b0;
      clamp_seen = 1'b0;
    end else begin
      if (req_valid && !req_stall) predict_beat(req);
      if (!req_valid || !req_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          req_valid <= 1'b0;
        end else if (pending.size() > TAIL && $urandom_range(0, 19) == 0) begin
          send_gap <= $urandom_range(0, 13);
          req_valid <= 1'b0;
        end else if (pending.size() > 0) begin
          req <= pending.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (!hold_done && results_seen == 3) begin
        hold_done <= 1;
        hold_left <= 6000;
        res_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        res_stall <= hold_left > 1;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        res_stall <= recv_gap > 1;
      end else if (pending.size() > TAIL && $urandom_range(0, 19) == 0) begin
        recv_gap <= $urandom_range(1, 14);
        res_stall <= 1'b1;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    res_t want;
    if (!rst && res_valid && !res_stall) begin
      results_seen <= results_seen + 1;
      if (sums_due.size() == 0) begin
        $error("result beat with nothing expected: sum %h", res.error_sum);
        fails++;
      end else begin
        want = sums_due.pop_front();
        if (res.error_sum !== want.error_sum) begin
          $error("error_sum: expected %h, got %h", want.error_sum, res.error_sum);
          fails++;
        end
        if (res.zero_depth_seen !== want.zero_depth_seen) begin
          $error("zero_depth_seen: expected %b, got %b", want.zero_depth_seen,
                 res.zero_depth_seen);
          fails++;
        end
        if (res.saturated !== want.saturated) begin
          $error("saturated: expected %b, got %b", want.saturated, res.saturated);
          fails++;
        end
      end
    end
  end
endmodule
